// ===== src/mcv_pkg.sv =====
`default_nettype none
package mcv_pkg;

	localparam int MCV_MAX_LOCKS = 16;
	localparam int MCV_MAX_PROCS = 16;

	// request codes
	typedef enum logic [2:0] {
		CMD_LOCK    = 3'd0,
		CMD_UNLOCK  = 3'd1,
		CMD_WAIT    = 3'd2,
		CMD_BCAST   = 3'd3,
		CMD_UNPAUSE = 3'd4,
		CMD_TERM    = 3'd5
	} cmd_t;

	// reply codes
	typedef enum logic [2:0] {
		ST_OK          = 3'd0,
		ST_NOT_OWNER   = 3'd1,
		ST_INVALID     = 3'd2,
		ST_INTERRUPTED = 3'd3,
		ST_NO_SPACE    = 3'd4
	} status_t;

	// reply destination select
	typedef enum logic [1:0] {
		DS_CALLER = 2'd0,
		DS_TARGET = 2'd1,
		DS_ACQ    = 2'd2,
		DS_QJ     = 2'd3
	} dsel_t;

	// controller to datapath
	typedef struct packed {
		logic    rdy;
		logic    set_acq_req;
		logic    set_acq_wait;
		logic    i_clr;
		logic    i_inc;
		logic    j_clr;
		logic    j_inc;
		logic    latch_k;
		logic    held_append;
		logic    held_drop_k;
		logic    held_hand;
		logic    q_append;
		logic    q_drop_i;
		logic    q_drop_j;
		logic    w_append;
		logic    w_drop_i;
		logic    emit;
		dsel_t   dsel;
		status_t est;
		logic    flush;
	} dp_cmd_t;

	// datapath to controller
	typedef struct packed {
		logic       req_valid;
		logic [2:0] cmd;
		logic       i_lt_h;
		logic       i_lt_q;
		logic       i_lt_w;
		logic       j_lt_h;
		logic       j_lt_q;
		logic       hit_acq_j;
		logic       hit_own_i;
		logic       tgt_h_i;
		logic       hit_rel_j;
		logic       tgt_q_i;
		logic       cond_w_i;
		logic       tgt_w_i;
		logic       h_full;
		logic       q_full;
		logic       w_full;
		logic       emit_ok;
		logic       pend_v;
	} dp_sts_t;

endpackage
`default_nettype wire

// ===== src/mcv_req_if.sv =====
`default_nettype none
interface mcv_req_if;
	logic        valid;
	logic        ready;
	logic [2:0]  cmd;
	logic [15:0] lock_id;
	logic [15:0] cond_id;
	logic [3:0]  caller_proc;
	logic [3:0]  target_proc;

	modport source (output valid, cmd, lock_id, cond_id, caller_proc, target_proc,
		input ready);
	modport sink (input valid, cmd, lock_id, cond_id, caller_proc, target_proc,
		output ready);
endinterface
`default_nettype wire

// ===== src/mcv_rsp_if.sv =====
`default_nettype none
interface mcv_rsp_if;
	logic       valid;
	logic       ready;
	logic [3:0] dest_proc;
	logic [2:0] status;
	logic       last;

	modport source (output valid, dest_proc, status, last, input ready);
	modport sink (input valid, dest_proc, status, last, output ready);
endinterface
`default_nettype wire

// ===== src/mutex_condvar_manager.sv =====
// Lock manager: held-lock table, lock-waiter FIFO and condition waiter list.
// One request at a time; each table search steps one entry per cycle.
// A reply waits while the output register is full, which stalls the sequencer.
// A new request is taken the cycle after the previous one ends; replies leave via
// an output register. Reset (arst_n low) empties all three stores at once.
`default_nettype none
module mutex_condvar_manager import mcv_pkg::*; #(
	parameter int MAX_LOCKS = MCV_MAX_LOCKS,
	parameter int MAX_PROCS = MCV_MAX_PROCS
) (
	input wire logic  clk,
	input wire logic  arst_n,
	mcv_req_if.sink   req,
	mcv_rsp_if.source rsp
);

	dp_cmd_t dp_cmd;
	dp_sts_t dp_sts;

	mcv_ctrl u_ctrl (
		.clk    (clk),
		.arst_n (arst_n),
		.sts    (dp_sts),
		.cmd    (dp_cmd)
	);

	mcv_datapath #(
		.MAX_LOCKS (MAX_LOCKS),
		.MAX_PROCS (MAX_PROCS)
	) u_datapath (
		.clk    (clk),
		.arst_n (arst_n),
		.req    (req),
		.rsp    (rsp),
		.cmd    (dp_cmd),
		.sts    (dp_sts)
	);

endmodule
`default_nettype wire

// ===== src/mcv_datapath.sv =====
`default_nettype none
module mcv_datapath import mcv_pkg::*; #(
	parameter int MAX_LOCKS = MCV_MAX_LOCKS,
	parameter int MAX_PROCS = MCV_MAX_PROCS
) (
	input  wire logic    clk,
	input  wire logic    arst_n,
	mcv_req_if.sink      req,
	mcv_rsp_if.source    rsp,
	input  wire dp_cmd_t cmd,
	output dp_sts_t      sts
);

	localparam int HCW = $clog2(MAX_LOCKS + 1);
	localparam int PCW = $clog2(MAX_PROCS + 1);
	localparam int IW  = (HCW > PCW) ? HCW : PCW;
	localparam int HIW = (MAX_LOCKS > 1) ? $clog2(MAX_LOCKS) : 1;
	localparam int PIW = (MAX_PROCS > 1) ? $clog2(MAX_PROCS) : 1;

	// stores
	logic [15:0] held_id_q   [MAX_LOCKS];
	logic [3:0]  held_own_q  [MAX_LOCKS];
	logic [15:0] q_lock_q    [MAX_PROCS];
	logic [3:0]  q_proc_q    [MAX_PROCS];
	logic [3:0]  w_proc_q    [MAX_PROCS];
	logic [15:0] w_lock_q    [MAX_PROCS];
	logic [15:0] w_cond_q    [MAX_PROCS];
	logic [HCW-1:0] hcnt_q;
	logic [PCW-1:0] qcnt_q;
	logic [PCW-1:0] wcnt_q;

	// request and work registers
	logic [2:0]  cmd_q;
	logic [15:0] lid_q, cid_q, acq_id_q, rel_id_q;
	logic [3:0]  caller_q, target_q, acq_p_q;
	logic [IW-1:0]  i_q, j_q;
	logic [HIW-1:0] k_q;

	// pending reply and output register
	logic       pend_v_q;
	logic [3:0] pend_dest_q;
	logic [2:0] pend_st_q;
	logic       out_v_q;
	logic [3:0] out_dest_q;
	logic [2:0] out_st_q;
	logic       out_last_q;

	logic [HIW-1:0] ih, jh;
	logic [PIW-1:0] iq, jq;
	logic           accept, out_free;
	logic [3:0]     emit_dest;

	assign ih = i_q[HIW-1:0];
	assign jh = j_q[HIW-1:0];
	assign iq = i_q[PIW-1:0];
	assign jq = j_q[PIW-1:0];

	assign req.ready = cmd.rdy;
	assign accept    = req.valid && cmd.rdy;
	assign out_free  = !out_v_q || rsp.ready;

	// status to the controller
	always_comb begin
		sts.req_valid = req.valid;
		sts.cmd       = cmd_q;
		sts.i_lt_h    = i_q < IW'(hcnt_q);
		sts.i_lt_q    = i_q < IW'(qcnt_q);
		sts.i_lt_w    = i_q < IW'(wcnt_q);
		sts.j_lt_h    = j_q < IW'(hcnt_q);
		sts.j_lt_q    = j_q < IW'(qcnt_q);
		sts.hit_acq_j = held_id_q[jh] == acq_id_q;
		sts.hit_own_i = (held_id_q[ih] == lid_q) && (held_own_q[ih] == caller_q);
		sts.tgt_h_i   = held_own_q[ih] == target_q;
		sts.hit_rel_j = q_lock_q[jq] == rel_id_q;
		sts.tgt_q_i   = q_proc_q[iq] == target_q;
		sts.cond_w_i  = w_cond_q[iq] == cid_q;
		sts.tgt_w_i   = w_proc_q[iq] == target_q;
		sts.h_full    = hcnt_q == HCW'(MAX_LOCKS);
		sts.q_full    = qcnt_q == PCW'(MAX_PROCS);
		sts.w_full    = wcnt_q == PCW'(MAX_PROCS);
		sts.emit_ok   = !pend_v_q || out_free;
		sts.pend_v    = pend_v_q;
	end

	// reply destination
	always_comb begin
		case (cmd.dsel)
			DS_CALLER: emit_dest = caller_q;
			DS_TARGET: emit_dest = target_q;
			DS_ACQ:    emit_dest = acq_p_q;
			default:   emit_dest = q_proc_q[jq];
		endcase
	end

	// request capture and scan registers
	always_ff @(posedge clk) begin
		if (accept) begin
			cmd_q    <= req.cmd;
			lid_q    <= req.lock_id;
			cid_q    <= req.cond_id;
			caller_q <= req.caller_proc;
			target_q <= req.target_proc;
		end
		if (cmd.set_acq_req) begin
			acq_id_q <= lid_q;
			acq_p_q  <= caller_q;
		end else if (cmd.set_acq_wait) begin
			acq_id_q <= w_lock_q[iq];
			acq_p_q  <= w_proc_q[iq];
		end
		if (cmd.latch_k) begin
			k_q      <= ih;
			rel_id_q <= held_id_q[ih];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			i_q <= '0;
			j_q <= '0;
		end else begin
			if (accept || cmd.i_clr) i_q <= '0;
			else if (cmd.i_inc)      i_q <= i_q + IW'(1);
			if (accept || cmd.j_clr) j_q <= '0;
			else if (cmd.j_inc)      j_q <= j_q + IW'(1);
		end
	end

	// held table: append, hand over, compact on drop
	always_ff @(posedge clk) begin
		if (cmd.held_drop_k) begin
			for (int e = 0; e < MAX_LOCKS - 1; e++) begin
				if (HIW'(e) >= k_q) begin
					held_id_q[e]  <= held_id_q[e + 1];
					held_own_q[e] <= held_own_q[e + 1];
				end
			end
		end
		if (cmd.held_append) begin
			held_id_q[hcnt_q[HIW-1:0]]  <= acq_id_q;
			held_own_q[hcnt_q[HIW-1:0]] <= acq_p_q;
		end
		if (cmd.held_hand) held_own_q[k_q] <= q_proc_q[jq];
	end

	// lock queue
	always_ff @(posedge clk) begin
		if (cmd.q_drop_i || cmd.q_drop_j) begin
			for (int e = 0; e < MAX_PROCS - 1; e++) begin
				if (PIW'(e) >= (cmd.q_drop_i ? iq : jq)) begin
					q_lock_q[e] <= q_lock_q[e + 1];
					q_proc_q[e] <= q_proc_q[e + 1];
				end
			end
		end
		if (cmd.q_append) begin
			q_lock_q[qcnt_q[PIW-1:0]] <= acq_id_q;
			q_proc_q[qcnt_q[PIW-1:0]] <= acq_p_q;
		end
	end

	// condition waiter list
	always_ff @(posedge clk) begin
		if (cmd.w_drop_i) begin
			for (int e = 0; e < MAX_PROCS - 1; e++) begin
				if (PIW'(e) >= iq) begin
					w_proc_q[e] <= w_proc_q[e + 1];
					w_lock_q[e] <= w_lock_q[e + 1];
					w_cond_q[e] <= w_cond_q[e + 1];
				end
			end
		end
		if (cmd.w_append) begin
			w_proc_q[wcnt_q[PIW-1:0]] <= caller_q;
			w_lock_q[wcnt_q[PIW-1:0]] <= lid_q;
			w_cond_q[wcnt_q[PIW-1:0]] <= cid_q;
		end
	end

	// fill counts
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			hcnt_q <= '0;
			qcnt_q <= '0;
			wcnt_q <= '0;
		end else begin
			if (cmd.held_append)      hcnt_q <= hcnt_q + HCW'(1);
			else if (cmd.held_drop_k) hcnt_q <= hcnt_q - HCW'(1);
			if (cmd.q_append)                     qcnt_q <= qcnt_q + PCW'(1);
			else if (cmd.q_drop_i || cmd.q_drop_j) qcnt_q <= qcnt_q - PCW'(1);
			if (cmd.w_append)      wcnt_q <= wcnt_q + PCW'(1);
			else if (cmd.w_drop_i) wcnt_q <= wcnt_q - PCW'(1);
		end
	end

	// pending reply: held back one step so the final one can carry last
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pend_v_q <= 1'b0;
			out_v_q  <= 1'b0;
		end else begin
			if (cmd.emit)       pend_v_q <= 1'b1;
			else if (cmd.flush) pend_v_q <= 1'b0;
			if ((cmd.emit || cmd.flush) && pend_v_q) out_v_q <= 1'b1;
			else if (rsp.ready)                      out_v_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.emit) begin
			pend_dest_q <= emit_dest;
			pend_st_q   <= cmd.est;
		end
		if ((cmd.emit || cmd.flush) && pend_v_q) begin
			out_dest_q <= pend_dest_q;
			out_st_q   <= pend_st_q;
			out_last_q <= cmd.flush;
		end
	end

	assign rsp.valid     = out_v_q;
	assign rsp.dest_proc = out_dest_q;
	assign rsp.status    = out_st_q;
	assign rsp.last      = out_last_q;

	// checks
	a_hcnt_range: assert property (@(posedge clk) disable iff (!arst_n)
		hcnt_q <= HCW'(MAX_LOCKS)) else $error("held count overrun");
	a_qcnt_range: assert property (@(posedge clk) disable iff (!arst_n)
		qcnt_q <= PCW'(MAX_PROCS)) else $error("queue count overrun");
	a_no_lost_reply: assert property (@(posedge clk) disable iff (!arst_n)
		((cmd.emit || cmd.flush) && pend_v_q) |-> out_free)
		else $error("reply pushed into busy output");
	a_append_room: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.held_append |-> (hcnt_q != HCW'(MAX_LOCKS)))
		else $error("append to full held table");

endmodule
`default_nettype wire

// ===== src/mcv_ctrl.sv =====
`default_nettype none
module mcv_ctrl import mcv_pkg::*; (
	input  wire logic    clk,
	input  wire logic    arst_n,
	input  wire dp_sts_t sts,
	output dp_cmd_t      cmd
);

	typedef enum logic [17:0] {
		S_IDLE      = 18'h00001,
		S_DISP      = 18'h00002,
		S_ACQ_SCAN  = 18'h00004,
		S_ACQ_Q     = 18'h00008,
		S_ACQ_GRANT = 18'h00010,
		S_OWN_SCAN  = 18'h00020,
		S_REL_SCAN  = 18'h00040,
		S_REL_HAND  = 18'h00080,
		S_REL_FREE  = 18'h00100,
		S_REL_RET   = 18'h00200,
		S_BC_SCAN   = 18'h00400,
		S_UP_QSCAN  = 18'h00800,
		S_UP_WSCAN  = 18'h01000,
		S_TQ_SCAN   = 18'h02000,
		S_TW_SCAN   = 18'h04000,
		S_TH_SCAN   = 18'h08000,
		S_FINISH    = 18'h10000,
		S_SPARE     = 18'h20000
	} state_t;

	state_t state_q, state_d;
	state_t acq_ret;
	logic   is_term;

	assign acq_ret = (sts.cmd == CMD_BCAST) ? S_BC_SCAN : S_FINISH;
	assign is_term = sts.cmd == CMD_TERM;

	// sequencer
	always_comb begin
		cmd     = '0;
		state_d = state_q;
		unique case (state_q)
			S_IDLE: begin
				cmd.rdy = 1'b1;
				if (sts.req_valid) state_d = S_DISP;
			end
			S_DISP: begin
				unique case (sts.cmd)
					CMD_LOCK: begin
						cmd.set_acq_req = 1'b1;
						state_d = S_ACQ_SCAN;
					end
					CMD_UNLOCK, CMD_WAIT: state_d = S_OWN_SCAN;
					CMD_BCAST: state_d = S_BC_SCAN;
					CMD_UNPAUSE: begin
						cmd.emit = 1'b1;
						cmd.dsel = DS_CALLER;
						cmd.est  = ST_OK;
						state_d  = S_UP_QSCAN;
					end
					CMD_TERM: begin
						cmd.emit = 1'b1;
						cmd.dsel = DS_CALLER;
						cmd.est  = ST_OK;
						state_d  = S_TQ_SCAN;
					end
					default: begin
						cmd.emit = 1'b1;
						cmd.dsel = DS_CALLER;
						cmd.est  = ST_INVALID;
						state_d  = S_FINISH;
					end
				endcase
			end
			// look for the lock among held entries
			S_ACQ_SCAN: begin
				if (sts.j_lt_h) begin
					if (sts.hit_acq_j) state_d = S_ACQ_Q;
					else cmd.j_inc = 1'b1;
				end else begin
					state_d = S_ACQ_GRANT;
				end
			end
			S_ACQ_Q: begin
				if (!sts.q_full) begin
					cmd.q_append = 1'b1;
					state_d = acq_ret;
				end else if (sts.emit_ok) begin
					cmd.emit = 1'b1;
					cmd.dsel = DS_ACQ;
					cmd.est  = ST_NO_SPACE;
					state_d  = acq_ret;
				end
			end
			S_ACQ_GRANT: begin
				if (sts.emit_ok) begin
					cmd.emit        = 1'b1;
					cmd.dsel        = DS_ACQ;
					cmd.est         = sts.h_full ? ST_NO_SPACE : ST_OK;
					cmd.held_append = !sts.h_full;
					state_d         = acq_ret;
				end
			end
			// ownership check for unlock and wait
			S_OWN_SCAN: begin
				if (sts.i_lt_h) begin
					if (sts.hit_own_i) begin
						if (sts.cmd == CMD_WAIT && sts.w_full) begin
							if (sts.emit_ok) begin
								cmd.emit = 1'b1;
								cmd.dsel = DS_CALLER;
								cmd.est  = ST_NO_SPACE;
								state_d  = S_FINISH;
							end
						end else begin
							cmd.latch_k = 1'b1;
							cmd.j_clr   = 1'b1;
							state_d     = S_REL_SCAN;
						end
					end else begin
						cmd.i_inc = 1'b1;
					end
				end else if (sts.emit_ok) begin
					cmd.emit = 1'b1;
					cmd.dsel = DS_CALLER;
					cmd.est  = (sts.cmd == CMD_UNLOCK) ? ST_NOT_OWNER : ST_INVALID;
					state_d  = S_FINISH;
				end
			end
			// release: find oldest waiter for the lock
			S_REL_SCAN: begin
				if (sts.j_lt_q) begin
					if (sts.hit_rel_j) state_d = S_REL_HAND;
					else cmd.j_inc = 1'b1;
				end else begin
					state_d = S_REL_FREE;
				end
			end
			S_REL_HAND: begin
				if (sts.emit_ok) begin
					cmd.held_hand = 1'b1;
					cmd.q_drop_j  = 1'b1;
					cmd.emit      = 1'b1;
					cmd.dsel      = DS_QJ;
					cmd.est       = ST_OK;
					cmd.i_inc     = is_term;
					state_d       = is_term ? S_TH_SCAN : S_REL_RET;
				end
			end
			S_REL_FREE: begin
				cmd.held_drop_k = 1'b1;
				state_d = is_term ? S_TH_SCAN : S_REL_RET;
			end
			S_REL_RET: begin
				if (sts.cmd == CMD_UNLOCK) begin
					if (sts.emit_ok) begin
						cmd.emit = 1'b1;
						cmd.dsel = DS_CALLER;
						cmd.est  = ST_OK;
						state_d  = S_FINISH;
					end
				end else begin
					cmd.w_append = 1'b1;
					state_d = S_FINISH;
				end
			end
			// broadcast: hand each waiter on the condition to the lock acquire path
			S_BC_SCAN: begin
				if (sts.i_lt_w) begin
					if (sts.cond_w_i) begin
						cmd.set_acq_wait = 1'b1;
						cmd.w_drop_i     = 1'b1;
						cmd.j_clr        = 1'b1;
						state_d          = S_ACQ_SCAN;
					end else begin
						cmd.i_inc = 1'b1;
					end
				end else if (sts.emit_ok) begin
					cmd.emit = 1'b1;
					cmd.dsel = DS_CALLER;
					cmd.est  = ST_OK;
					state_d  = S_FINISH;
				end
			end
			S_UP_QSCAN: begin
				if (sts.i_lt_q) begin
					if (sts.tgt_q_i) begin
						if (sts.emit_ok) begin
							cmd.q_drop_i = 1'b1;
							cmd.emit     = 1'b1;
							cmd.dsel     = DS_TARGET;
							cmd.est      = ST_INTERRUPTED;
							state_d      = S_FINISH;
						end
					end else begin
						cmd.i_inc = 1'b1;
					end
				end else begin
					cmd.i_clr = 1'b1;
					state_d = S_UP_WSCAN;
				end
			end
			S_UP_WSCAN: begin
				if (sts.i_lt_w) begin
					if (sts.tgt_w_i) begin
						if (sts.emit_ok) begin
							cmd.w_drop_i = 1'b1;
							cmd.emit     = 1'b1;
							cmd.dsel     = DS_TARGET;
							cmd.est      = ST_INTERRUPTED;
							state_d      = S_FINISH;
						end
					end else begin
						cmd.i_inc = 1'b1;
					end
				end else begin
					state_d = S_FINISH;
				end
			end
			// terminate: purge queue, then waiters, then held locks
			S_TQ_SCAN: begin
				if (sts.i_lt_q) begin
					if (sts.tgt_q_i) cmd.q_drop_i = 1'b1;
					else cmd.i_inc = 1'b1;
				end else begin
					cmd.i_clr = 1'b1;
					state_d = S_TW_SCAN;
				end
			end
			S_TW_SCAN: begin
				if (sts.i_lt_w) begin
					if (sts.tgt_w_i) cmd.w_drop_i = 1'b1;
					else cmd.i_inc = 1'b1;
				end else begin
					cmd.i_clr = 1'b1;
					state_d = S_TH_SCAN;
				end
			end
			S_TH_SCAN: begin
				if (sts.i_lt_h) begin
					if (sts.tgt_h_i) begin
						cmd.latch_k = 1'b1;
						cmd.j_clr   = 1'b1;
						state_d     = S_REL_SCAN;
					end else begin
						cmd.i_inc = 1'b1;
					end
				end else begin
					state_d = S_FINISH;
				end
			end
			// push the held-back reply marked last
			S_FINISH: begin
				if (!sts.pend_v) begin
					state_d = S_IDLE;
				end else if (sts.emit_ok) begin
					cmd.flush = 1'b1;
					state_d = S_IDLE;
				end
			end
			default: state_d = S_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) state_q <= S_IDLE;
		else         state_q <= state_d;
	end

	a_one_hot: assert property (@(posedge clk) disable iff (!arst_n)
		$onehot(state_q)) else $error("state not one-hot");
	a_idle_no_emit: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == S_IDLE) |-> !cmd.emit && !sts.pend_v)
		else $error("reply left pending in idle");
	a_accept_next: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == S_IDLE && sts.req_valid) |=> (state_q == S_DISP))
		else $error("accepted item not dispatched");

endmodule
`default_nettype wire
